// File: src/stc_pkg.sv
// Package for the supersampled triangle coverage block.
// Holds shared widths, register indexes, state and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    // Default values of the top level parameters.
    localparam int DEF_SCREEN_WIDTH  = 512;
    localparam int DEF_SCREEN_HEIGHT = 512;
    localparam int DEF_MAX_FACTOR    = 8;

    // Field widths fixed by the interface.
    localparam int COORD_IN_W   = 9;
    localparam int VERT_W       = 9;
    localparam int FACTOR_REG_W = 4;
    localparam int COUNT_OUT_W  = 7;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 9;

    // Reset value of the subsample factor register.
    localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = 4'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_VERT0_X = 3'd0,
        REG_VERT0_Y = 3'd1,
        REG_VERT1_X = 3'd2,
        REG_VERT1_Y = 3'd3,
        REG_VERT2_X = 3'd4,
        REG_VERT2_Y = 3'd5,
        REG_FACTOR  = 3'd6
    } t_cfg_reg;

    // Products formed by the shared multiplier, in issue order.
    typedef enum logic [2:0] {
        MUL_E0_A = 3'd0,
        MUL_E0_B = 3'd1,
        MUL_E1_A = 3'd2,
        MUL_E1_B = 3'd3,
        MUL_E2_A = 3'd4,
        MUL_E2_B = 3'd5,
        MUL_G_A  = 3'd6,
        MUL_G_B  = 3'd7
    } t_mul_step;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SCALE    = 3'd1,
        ST_DIFF     = 3'd2,
        ST_MUL      = 3'd3,
        ST_MUL_TAIL = 3'd4,
        ST_RUN      = 3'd5,
        ST_DONE     = 3'd6
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      scale;
        logic      diff;
        logic      mul_issue;
        t_mul_step mul_step;
        logic      run;
        logic      out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic off_screen;
        logic col_last;
        logic row_last;
    } t_status;

endpackage

`default_nettype wire

// File: src/stc_ctrl.sv
// Controller state machine for the supersampled triangle coverage block.
// Sequences setup, the multiply steps and the subsample sweep; owns the output valid.
// Depends on stc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output stc_pkg::t_cmd        o_cmd,
    input  wire stc_pkg::t_status i_status
);
    import stc_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_mul_step r_mul_step;
    t_mul_step n_mul_step;
    logic      r_out_valid;
    logic      n_out_valid;

    // State, step counter and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mul_step  <= MUL_E0_A;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mul_step  <= n_mul_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_mul_step = r_mul_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = i_status.off_screen ? ST_DONE : ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_mul_step = MUL_E0_A;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_issue = 1'b1;
                o_cmd.mul_step  = r_mul_step;
                if (r_mul_step == MUL_G_B) begin
                    n_state = ST_MUL_TAIL;
                end else begin
                    n_mul_step = t_mul_step'(r_mul_step + 3'd1);
                end
            end
            ST_MUL_TAIL: begin
                // The last product is folded into the area term here.
                n_state = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.run = 1'b1;
                if (i_status.col_last && i_status.row_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the result is taken.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/stc_datapath.sv
// Datapath for the supersampled triangle coverage block: configuration registers,
// vertex scaling, shared edge multiplier, incremental edge walk and result register.
// Depends on stc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stc_datapath #(
    parameter int SCREEN_WIDTH  = stc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = stc_pkg::DEF_SCREEN_HEIGHT,
    parameter int MAX_FACTOR    = stc_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [stc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic [stc_pkg::COORD_IN_W-1:0]     i_pixel_column,
    input  wire logic [stc_pkg::COORD_IN_W-1:0]     i_pixel_row,
    input  wire stc_pkg::t_cmd                      i_cmd,
    output stc_pkg::t_status                        o_status,
    output logic [stc_pkg::COUNT_OUT_W-1:0]         o_covered_count,
    output logic                                    o_fully_covered
);
    import stc_pkg::*;

    localparam int MAX_SIDE = SCREEN_WIDTH > SCREEN_HEIGHT ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int MAX_DIM  = MAX_SIDE > 512 ? MAX_SIDE : 512;
    // Signed width of scaled coordinates and their differences.
    localparam int CW       = $clog2(MAX_DIM * MAX_FACTOR + 1) + 1;
    // Width of edge function values.
    localparam int EW       = 2 * CW + 1;
    localparam int FW       = $clog2(MAX_FACTOR + 1);
    localparam int SQ_W     = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int CNTW     = SQ_W > COUNT_OUT_W ? SQ_W : COUNT_OUT_W;

    // Configuration registers.
    logic [VERT_W-1:0]       r_vert [6];
    logic [FACTOR_REG_W-1:0] r_cfg_factor;

    // Load stage.
    logic [COORD_IN_W-1:0] r_col;
    logic [CW-1:0]         r_hrow;
    logic [FW-1:0]         r_fe;
    logic [FW-1:0]         n_fe;
    logic                  r_off;

    // Scale stage.
    logic signed [CW-1:0] r_vs [6];
    logic signed [CW-1:0] r_x0;
    logic signed [CW-1:0] r_y0;
    logic [FW-1:0]        r_fm1;
    logic [CNTW-1:0]      r_ff;

    // Difference stage.
    logic signed [CW-1:0] r_a  [3];
    logic signed [CW-1:0] r_b  [3];
    logic signed [CW-1:0] r_px [3];
    logic signed [CW-1:0] r_py [3];
    logic signed [CW-1:0] r_xmin;
    logic signed [CW-1:0] r_xmax;
    logic signed [CW-1:0] r_ymin;
    logic signed [CW-1:0] r_ymax;

    // Shared multiplier.
    logic signed [CW-1:0]   w_op_a;
    logic signed [CW-1:0]   w_op_b;
    logic signed [2*CW-1:0] w_prod;
    logic signed [2*CW-1:0] r_prod;
    t_mul_step              r_prod_step;
    logic                   r_prod_vld;

    // Edge values at the current subsample and at the start of the current row.
    logic signed [EW-1:0] r_e  [3];
    logic signed [EW-1:0] r_er [3];
    logic signed [EW-1:0] r_g;

    // Subsample walk.
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic [FW-1:0]        r_k;
    logic [FW-1:0]        r_l;
    logic [CNTW-1:0]      r_count;
    logic                 w_hit;
    logic                 w_in_box;
    logic                 w_all_ge;
    logic                 w_all_le;
    logic                 w_g_pos;
    logic                 w_g_neg;

    // Result register.
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic                   r_out_full;

    function automatic logic signed [CW-1:0] min3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CW-1:0] max3(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic signed [CW-1:0] c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert[0]    <= '0;
            r_vert[1]    <= '0;
            r_vert[2]    <= '0;
            r_vert[3]    <= '0;
            r_vert[4]    <= '0;
            r_vert[5]    <= '0;
            r_cfg_factor <= FACTOR_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_VERT0_X: r_vert[0]    <= i_cfg_wdata;
                REG_VERT0_Y: r_vert[1]    <= i_cfg_wdata;
                REG_VERT1_X: r_vert[2]    <= i_cfg_wdata;
                REG_VERT1_Y: r_vert[3]    <= i_cfg_wdata;
                REG_VERT2_X: r_vert[4]    <= i_cfg_wdata;
                REG_VERT2_Y: r_vert[5]    <= i_cfg_wdata;
                REG_FACTOR:  r_cfg_factor <= i_cfg_wdata[FACTOR_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Effective factor: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (r_cfg_factor == '0) begin
            n_fe = FW'(1);
        end else if (32'(r_cfg_factor) > 32'(MAX_FACTOR)) begin
            n_fe = FW'(MAX_FACTOR);
        end else begin
            n_fe = FW'(r_cfg_factor);
        end
    end

    // Load stage: capture the pixel and the effective factor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col  <= i_pixel_column;
            r_hrow <= CW'(SCREEN_HEIGHT) - CW'(i_pixel_row);
            r_fe   <= n_fe;
            r_off  <= (32'(i_pixel_column) >= 32'(SCREEN_WIDTH)) ||
                      (32'(i_pixel_row) >= 32'(SCREEN_HEIGHT));
        end
    end

    // Scale stage: vertices, first subsample position and the full count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            for (int i = 0; i < 6; i++) begin
                r_vs[i] <= CW'(r_vert[i]) * CW'(r_fe);
            end
            r_x0  <= CW'(r_col) * CW'(r_fe);
            r_y0  <= r_hrow * CW'(r_fe);
            r_fm1 <= r_fe - FW'(1);
            r_ff  <= CNTW'(r_fe) * CNTW'(r_fe);
        end
    end

    // Difference stage: edge slopes, offsets from the vertices and bounding box.
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_a[0]  <= r_vs[3] - r_vs[1];
            r_b[0]  <= r_vs[2] - r_vs[0];
            r_a[1]  <= r_vs[5] - r_vs[3];
            r_b[1]  <= r_vs[4] - r_vs[2];
            r_a[2]  <= r_vs[1] - r_vs[5];
            r_b[2]  <= r_vs[0] - r_vs[4];
            r_px[0] <= r_x0 - r_vs[0];
            r_py[0] <= r_y0 - r_vs[1];
            r_px[1] <= r_x0 - r_vs[2];
            r_py[1] <= r_y0 - r_vs[3];
            r_px[2] <= r_x0 - r_vs[4];
            r_py[2] <= r_y0 - r_vs[5];
            r_xmin  <= min3(r_vs[0], r_vs[2], r_vs[4]);
            r_xmax  <= max3(r_vs[0], r_vs[2], r_vs[4]);
            r_ymin  <= min3(r_vs[1], r_vs[3], r_vs[5]);
            r_ymax  <= max3(r_vs[1], r_vs[3], r_vs[5]);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_step)
            MUL_E0_A: begin w_op_a = r_px[0]; w_op_b = r_a[0]; end
            MUL_E0_B: begin w_op_a = r_py[0]; w_op_b = r_b[0]; end
            MUL_E1_A: begin w_op_a = r_px[1]; w_op_b = r_a[1]; end
            MUL_E1_B: begin w_op_a = r_py[1]; w_op_b = r_b[1]; end
            MUL_E2_A: begin w_op_a = r_px[2]; w_op_b = r_a[2]; end
            MUL_E2_B: begin w_op_a = r_py[2]; w_op_b = r_b[2]; end
            MUL_G_A:  begin w_op_a = r_a[0];  w_op_b = r_b[1]; end
            MUL_G_B:  begin w_op_a = r_b[0];  w_op_b = r_a[1]; end
            default:  begin w_op_a = '0;      w_op_b = '0;     end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // Product register; its valid flag is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_issue) begin
            r_prod      <= w_prod;
            r_prod_step <= i_cmd.mul_step;
        end
    end

    // Subsample hit test at the current position.
    always_comb begin
        w_in_box = (r_x >= r_xmin) && (r_x < r_xmax) && (r_y >= r_ymin) && (r_y <= r_ymax);
        w_all_ge = !r_e[0][EW-1] && !r_e[1][EW-1] && !r_e[2][EW-1];
        w_all_le = (r_e[0][EW-1] || (r_e[0] == '0)) &&
                   (r_e[1][EW-1] || (r_e[1] == '0)) &&
                   (r_e[2][EW-1] || (r_e[2] == '0));
        w_g_neg  = r_g[EW-1];
        w_g_pos  = !r_g[EW-1] && (r_g != '0);
        w_hit    = w_in_box && ((w_g_pos && w_all_ge) || (w_g_neg && w_all_le));
    end

    // Edge accumulation during setup, then the incremental walk over the subsamples.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= '0;
        end
        if (i_cmd.diff) begin
            r_x <= r_x0;
            r_y <= r_y0;
            r_k <= '0;
            r_l <= '0;
        end
        if (r_prod_vld) begin
            case (r_prod_step)
                MUL_E0_A: begin r_e[0] <= EW'(r_prod); r_er[0] <= EW'(r_prod); end
                MUL_E0_B: begin
                    r_e[0]  <= r_e[0] - EW'(r_prod);
                    r_er[0] <= r_e[0] - EW'(r_prod);
                end
                MUL_E1_A: begin r_e[1] <= EW'(r_prod); r_er[1] <= EW'(r_prod); end
                MUL_E1_B: begin
                    r_e[1]  <= r_e[1] - EW'(r_prod);
                    r_er[1] <= r_e[1] - EW'(r_prod);
                end
                MUL_E2_A: begin r_e[2] <= EW'(r_prod); r_er[2] <= EW'(r_prod); end
                MUL_E2_B: begin
                    r_e[2]  <= r_e[2] - EW'(r_prod);
                    r_er[2] <= r_e[2] - EW'(r_prod);
                end
                MUL_G_A:  r_g <= EW'(r_prod);
                MUL_G_B:  r_g <= r_g - EW'(r_prod);
                default: begin
                end
            endcase
        end
        if (i_cmd.run) begin
            r_count <= r_count + CNTW'(w_hit);
            if (r_l == r_fm1) begin
                // Next row of subsamples: y drops by one, x returns to the left edge.
                r_l <= '0;
                r_k <= r_k + FW'(1);
                r_x <= r_x0;
                r_y <= r_y - CW'(1);
                for (int i = 0; i < 3; i++) begin
                    r_e[i]  <= r_er[i] + EW'(r_b[i]);
                    r_er[i] <= r_er[i] + EW'(r_b[i]);
                end
            end else begin
                r_l <= r_l + FW'(1);
                r_x <= r_x + CW'(1);
                for (int i = 0; i < 3; i++) begin
                    r_e[i] <= r_e[i] + EW'(r_a[i]);
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_count[COUNT_OUT_W-1:0];
            r_out_full  <= (r_count == r_ff);
        end
    end

    assign o_status.off_screen = r_off;
    assign o_status.col_last   = (r_l == r_fm1);
    assign o_status.row_last   = (r_k == r_fm1);
    assign o_covered_count     = r_out_count;
    assign o_fully_covered     = r_out_full;

endmodule

`default_nettype wire

// File: src/supersampled_triangle_coverage_core.sv
// Top level of the supersampled triangle coverage block.
// Instantiates the controller stc_ctrl and the datapath stc_datapath; uses stc_pkg.
//
// Usage: the triangle's three vertices (output pixel units, y origin at the bottom)
// and the subsample factor f are written through the configuration port while the
// block is idle. Each request on the slave stream carries one pixel (column, row
// counted from the top). The block answers each request with one result on the
// master stream: the number of covered f-by-f subsamples and a flag that is set
// when all of them are covered.
// Flow: an accepted on-screen pixel passes through the scale, difference, multiply,
// multiply tail and subsample sweep states, then its result is loaded into the
// output register. The subsample sweep tests one subsample per cycle in
// a single edge walker; setup runs eight products through one shared multiplier.
// An off-screen pixel goes from the scale state straight to the result and returns zero.
// The block takes one pixel at a time. A finished result waits in the output
// register while the receiver stalls; the next pixel is then accepted and computed,
// and its result holds in the final state until the output register frees.
// Reset sets all vertices to zero, the factor to 4 and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module supersampled_triangle_coverage_core #(
    parameter int SCREEN_WIDTH  = stc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = stc_pkg::DEF_SCREEN_HEIGHT,
    parameter int MAX_FACTOR    = stc_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write port.
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [stc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Pixel requests.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [8:0] pixel_column, [17:9] pixel_row, [23:18] zero
    input  wire logic [stc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Coverage results.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [6:0] covered_count, [7] fully_covered
    output logic [stc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import stc_pkg::*;

    t_cmd                   w_cmd;
    t_status                w_status;
    logic [COUNT_OUT_W-1:0] w_covered_count;
    logic                   w_fully_covered;

    // Sequencer.
    stc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Arithmetic and storage.
    stc_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_FACTOR    (MAX_FACTOR)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_pixel_column  (s_axis_tdata[COORD_IN_W-1:0]),
        .i_pixel_row     (s_axis_tdata[2*COORD_IN_W-1:COORD_IN_W]),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_covered_count (w_covered_count),
        .o_fully_covered (w_fully_covered)
    );

    // Pack the result fields, count in the low bits.
    assign m_axis_tdata = {w_fully_covered, w_covered_count};

endmodule

`default_nettype wire

// File: sim/stc_coverage_checker.sv
// Coverage checker for the supersampled triangle coverage block.
// Tracks configuration writes, predicts each pixel's coverage and compares results.
// Depends on stc_pkg for widths and register indexes.
`timescale 1ns / 1ps

module stc_coverage_checker #(
    parameter int SCREEN_WIDTH  = stc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = stc_pkg::DEF_SCREEN_HEIGHT,
    parameter int MAX_FACTOR    = stc_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [stc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                               i_s_tvalid,
    input  wire logic                               i_s_tready,
    // [8:0] pixel_column, [17:9] pixel_row, [23:18] zero
    input  wire logic [stc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  wire logic                               i_m_tvalid,
    input  wire logic                               i_m_tready,
    // [6:0] covered_count, [7] fully_covered
    input  wire logic [stc_pkg::OUT_TDATA_W-1:0]    i_m_tdata,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    import stc_pkg::*;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   full;
    } t_coverage;

    // Shadow copy of the triangle and the subsample factor.
    logic [VERT_W-1:0]       vert_x [3];
    logic [VERT_W-1:0]       vert_y [3];
    logic [FACTOR_REG_W-1:0] factor;

    // Coverage results still owed by the block, oldest first.
    t_coverage coverage_owed_q [$];

    // Signed edge function of point (x, y) against the edge from a to b.
    function automatic longint edge_fn(input longint x, input longint y,
                                       input longint ax, input longint ay,
                                       input longint bx, input longint by);
        return (x - ax) * (by - ay) - (y - ay) * (bx - ax);
    endfunction

    // Count the covered subsamples of one pixel with the current settings.
    function automatic t_coverage predict_coverage(input logic [COORD_IN_W-1:0] col,
                                                   input logic [COORD_IN_W-1:0] row);
        longint    f, g, x, y, e0, e1, e2;
        longint    xmin, xmax, ymin, ymax;
        longint    sx [3];
        longint    sy [3];
        int        hits;
        t_coverage res;
        res  = '0;
        hits = 0;
        // A zero factor behaves as one; anything above the maximum saturates.
        f = longint'(factor);
        if (f < 1) f = 1;
        if (f > MAX_FACTOR) f = MAX_FACTOR;
        if (col >= SCREEN_WIDTH || row >= SCREEN_HEIGHT) return res;
        for (int i = 0; i < 3; i++) begin
            sx[i] = longint'(vert_x[i]) * f;
            sy[i] = longint'(vert_y[i]) * f;
        end
        // Twice the signed area; a flat triangle covers nothing.
        g = (sx[0] - sx[1]) * (sy[2] - sy[1]) - (sy[0] - sy[1]) * (sx[2] - sx[1]);
        if (g == 0) return res;
        xmin = sx[0]; xmax = sx[0]; ymin = sy[0]; ymax = sy[0];
        for (int i = 1; i < 3; i++) begin
            if (sx[i] < xmin) xmin = sx[i];
            if (sx[i] > xmax) xmax = sx[i];
            if (sy[i] < ymin) ymin = sy[i];
            if (sy[i] > ymax) ymax = sy[i];
        end
        // Sweep the subsample grid; rows count down from the top of the screen.
        for (longint k = 0; k < f; k++) begin
            y = longint'(SCREEN_HEIGHT) * f - (longint'(row) * f + k);
            for (longint l = 0; l < f; l++) begin
                x = longint'(col) * f + l;
                if (x < xmin || x >= xmax || y < ymin || y > ymax) continue;
                e0 = edge_fn(x, y, sx[0], sy[0], sx[1], sy[1]);
                e1 = edge_fn(x, y, sx[1], sy[1], sx[2], sy[2]);
                e2 = edge_fn(x, y, sx[2], sy[2], sx[0], sy[0]);
                if ((g > 0 && e0 >= 0 && e1 >= 0 && e2 >= 0) ||
                    (g < 0 && e0 <= 0 && e1 <= 0 && e2 <= 0))
                    hits++;
            end
        end
        res.count = COUNT_OUT_W'(hits);
        res.full  = (longint'(hits) == f * f);
        return res;
    endfunction

    // Watch configuration, requests and results at each rising edge.
    always @(posedge i_clk) begin : monitor
        t_coverage want;
        t_coverage got;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                vert_x[i] = '0;
                vert_y[i] = '0;
            end
            factor = FACTOR_RESET;
            coverage_owed_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_VERT0_X: vert_x[0] = i_cfg_wdata[VERT_W-1:0];
                    REG_VERT0_Y: vert_y[0] = i_cfg_wdata[VERT_W-1:0];
                    REG_VERT1_X: vert_x[1] = i_cfg_wdata[VERT_W-1:0];
                    REG_VERT1_Y: vert_y[1] = i_cfg_wdata[VERT_W-1:0];
                    REG_VERT2_X: vert_x[2] = i_cfg_wdata[VERT_W-1:0];
                    REG_VERT2_Y: vert_y[2] = i_cfg_wdata[VERT_W-1:0];
                    REG_FACTOR:  factor    = i_cfg_wdata[FACTOR_REG_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                coverage_owed_q.push_back(predict_coverage(
                    i_s_tdata[COORD_IN_W-1:0], i_s_tdata[2*COORD_IN_W-1:COORD_IN_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.count = i_m_tdata[COUNT_OUT_W-1:0];
                got.full  = i_m_tdata[COUNT_OUT_W];
                if (coverage_owed_q.size() == 0) begin
                    $display("%0t: result with nothing owed: covered_count %0d fully_covered %0d",
                             $time, got.count, got.full);
                    o_fail_count++;
                end else begin
                    want = coverage_owed_q.pop_front();
                    if (got.count !== want.count) begin
                        $display("%0t: covered_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        o_fail_count++;
                    end
                    if (got.full !== want.full) begin
                        $display("%0t: fully_covered expected %0d actual %0d",
                                 $time, want.full, got.full);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = coverage_owed_q.size();
    end

endmodule

// File: sim/tb_supersampled_triangle_coverage_core.sv
// Testbench top for the supersampled triangle coverage block.
// Drives triangles and pixel requests with random stalls; stc_coverage_checker judges results.
// Depends on stc_pkg, supersampled_triangle_coverage_core and stc_coverage_checker.
`timescale 1ns / 1ps

module tb_supersampled_triangle_coverage_core;

    import stc_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTINGS_PER_MODE = 9;
    localparam int PIXELS_PER_SETTING = 50;
    localparam int COORD_MAX       = (1 << COORD_IN_W) - 1;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_off_req;
    int hold_left;
    int fail_count;
    int pending_count;

    // Triangle currently loaded, in output pixel units.
    int tri_x [3];
    int tri_y [3];

    supersampled_triangle_coverage_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    stc_coverage_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Hard limit on the run time, far above the slowest correct run.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result receiver: random stalls, plus a long hold-off when requested.
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Stop offering requests and wait until every result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge clk);
    endtask

    // Load a triangle and a factor once the block has gone idle.
    task automatic load_triangle(input int x0, input int y0, input int x1, input int y1,
                                 input int x2, input int y2, input int f);
        wait_drained();
        tri_x[0] = x0; tri_y[0] = y0;
        tri_x[1] = x1; tri_y[1] = y1;
        tri_x[2] = x2; tri_y[2] = y2;
        write_reg(REG_VERT0_X, x0);
        write_reg(REG_VERT0_Y, y0);
        write_reg(REG_VERT1_X, x1);
        write_reg(REG_VERT1_Y, y1);
        write_reg(REG_VERT2_X, x2);
        write_reg(REG_VERT2_Y, y2);
        write_reg(REG_FACTOR, f);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one pixel request and hold it until it is accepted.
    task automatic send_pixel(input int col, input int row);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - 2*COORD_IN_W){1'b0}},
                     COORD_IN_W'(row), COORD_IN_W'(col)};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Pick a pixel, mostly around the triangle's box so edges get exercised.
    task automatic send_near_triangle();
        int xmin, xmax, ymin, ymax;
        int col, row;
        xmin = tri_x[0]; xmax = tri_x[0]; ymin = tri_y[0]; ymax = tri_y[0];
        for (int i = 1; i < 3; i++) begin
            if (tri_x[i] < xmin) xmin = tri_x[i];
            if (tri_x[i] > xmax) xmax = tri_x[i];
            if (tri_y[i] < ymin) ymin = tri_y[i];
            if (tri_y[i] > ymax) ymax = tri_y[i];
        end
        if ($urandom_range(99) < 20) begin
            col = $urandom_range(COORD_MAX);
            row = $urandom_range(COORD_MAX);
        end else begin
            col = $urandom_range(clamp_coord(xmin - 2), clamp_coord(xmax + 1));
            // Pixel row r spans y from about 511 - r to 512 - r.
            row = $urandom_range(clamp_coord(COORD_MAX - ymax - 1),
                                 clamp_coord(COORD_MAX + 2 - ymin));
        end
        send_pixel(col, row);
    endtask

    // Random triangle of random size; now and then a flat one.
    task automatic load_random_triangle();
        int span, cx, cy;
        int vx [3];
        int vy [3];
        case ($urandom_range(3))
            0: span = 3;
            1: span = 16;
            2: span = 80;
            default: span = COORD_MAX;
        endcase
        cx = $urandom_range(COORD_MAX);
        cy = $urandom_range(COORD_MAX);
        for (int i = 0; i < 3; i++) begin
            vx[i] = clamp_coord(cx + int'($urandom_range(2*span)) - span);
            vy[i] = clamp_coord(cy + int'($urandom_range(2*span)) - span);
        end
        if ($urandom_range(9) == 0) begin
            vx[2] = vx[0];
            vy[2] = vy[0];
        end
        load_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], $urandom_range(15));
    endtask

    // Stimulus: reset, directed pixels, then random phases under three stall mixes.
    initial begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b0;
        tri_x        = '{0, 0, 0};
        tri_y        = '{0, 0, 0};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: all vertices at the origin, so nothing is covered.
        send_pixel(0, 0);
        send_pixel(COORD_MAX, COORD_MAX);

        // Half-screen triangle at the largest factor, corners and middle.
        load_triangle(0, 0, COORD_MAX, 0, 0, COORD_MAX, 8);
        send_pixel(0, 0);
        send_pixel(0, COORD_MAX);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(COORD_MAX, 0);
        send_pixel(100, 100);
        send_pixel(255, 256);

        // Same triangle wound the other way.
        load_triangle(0, 0, 0, COORD_MAX, COORD_MAX, 0, 3);
        send_pixel(0, COORD_MAX);
        send_pixel(10, 400);
        send_pixel(300, 300);

        // Collinear vertices.
        load_triangle(10, 10, 20, 20, 30, 30, 2);
        send_pixel(20, 492);
        send_pixel(15, 497);

        // Zero factor behaves as one.
        load_triangle(100, 100, 200, 100, 150, 300, 0);
        send_pixel(150, 300);
        send_pixel(150, 362);
        send_pixel(100, 411);

        // Factor above the maximum saturates.
        load_triangle(100, 100, 200, 100, 150, 300, 15);
        send_pixel(150, 362);
        send_pixel(120, 400);
        send_pixel(199, 411);

        // Tiny triangle at factor one.
        load_triangle(5, 5, 6, 5, 5, 6, 1);
        send_pixel(5, 506);
        send_pixel(5, 507);

        // Random phases: receiver-heavy stalls, sender-heavy stalls, then none.
        for (int mode = 0; mode < 3; mode++) begin
            for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
                if (s == 0) begin
                    case (mode)
                        0: load_triangle(0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 15);
                        1: load_triangle(COORD_MAX, 0, 0, 0, COORD_MAX, COORD_MAX, 0);
                        default: load_triangle(0, 0, COORD_MAX, 0, 256, COORD_MAX, 1);
                    endcase
                end else begin
                    load_random_triangle();
                end
                case (mode)
                    0: begin tx_idle_pct = 13; rx_idle_pct = 75; end
                    1: begin tx_idle_pct = 75; rx_idle_pct = 13; end
                    default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
                endcase
                // Long receiver hold-off so the block backs up into its input.
                if (mode == 2 && s == 0) hold_off_req = 1'b1;
                for (int n = 0; n < PIXELS_PER_SETTING; n++) begin
                    // Once, let the pipeline empty completely mid-phase.
                    if (mode == 0 && s == 1 && n == PIXELS_PER_SETTING / 2) wait_drained();
                    send_near_triangle();
                end
            end
        end

        wait_drained();
        repeat (100) @(negedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
src/stc_pkg.sv
src/stc_ctrl.sv
src/stc_datapath.sv
src/supersampled_triangle_coverage_core.sv
sim/stc_coverage_checker.sv
sim/tb_supersampled_triangle_coverage_core.sv
